// ===== hdl/mtt_pkg.sv =====
// Shared types, constants and the microcode ROM of the max tournament tree unit.
// Depends on nothing; imported by max_tournament_tree_unit.

package mtt_pkg;

    localparam int LEAF_IDX_W         = 8;
    localparam int VALUE_W            = 64;
    localparam int CNT_W              = 9;
    localparam int DEFAULT_MAX_LEAVES = 256;

    // One tree node as held in the node memory.
    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [LEAF_IDX_W-1:0] winner;
    } node_t;

    // Sequencer steps, also the addresses of the microcode ROM.
    typedef enum logic [2:0] {
        STEP_CLEAR,
        STEP_IDLE,
        STEP_LEAF,
        STEP_CLIMB,
        STEP_ROOT,
        STEP_OUT
    } step_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_LEAF,
        WR_CLIMB
    } wr_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_LEAF_SIB,
        RD_CLIMB_SIB,
        RD_ROOT
    } rd_op_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_CLR_BUSY,
        CND_NO_INPUT,
        CND_LEAF_SKIP,
        CND_CLIMB_MORE,
        CND_OUT_FULL
    } cond_t;

    // One control word: datapath controls, then a conditional jump.
    typedef struct packed {
        logic   in_rdy;
        logic   out_load;
        wr_op_t wr;
        rd_op_t rd;
        cond_t  cond;
        step_t  jump_step;
        step_t  next_step;
    } uword_t;

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        w = '{in_rdy: 1'b0, out_load: 1'b0, wr: WR_NONE, rd: RD_NONE,
              cond: CND_NEVER, jump_step: STEP_CLEAR, next_step: STEP_CLEAR};
        unique case (step)
            STEP_CLEAR:
            begin
                w.wr        = WR_CLEAR;
                w.cond      = CND_CLR_BUSY;
                w.jump_step = STEP_CLEAR;
                w.next_step = STEP_IDLE;
            end
            STEP_IDLE:
            begin
                w.in_rdy    = 1'b1;
                w.cond      = CND_NO_INPUT;
                w.jump_step = STEP_IDLE;
                w.next_step = STEP_LEAF;
            end
            STEP_LEAF:
            begin
                w.wr        = WR_LEAF;
                w.rd        = RD_LEAF_SIB;
                w.cond      = CND_LEAF_SKIP;
                w.jump_step = STEP_ROOT;
                w.next_step = STEP_CLIMB;
            end
            STEP_CLIMB:
            begin
                w.wr        = WR_CLIMB;
                w.rd        = RD_CLIMB_SIB;
                w.cond      = CND_CLIMB_MORE;
                w.jump_step = STEP_CLIMB;
                w.next_step = STEP_ROOT;
            end
            STEP_ROOT:
            begin
                w.rd        = RD_ROOT;
                w.next_step = STEP_OUT;
            end
            STEP_OUT:
            begin
                w.out_load  = 1'b1;
                w.cond      = CND_OUT_FULL;
                w.jump_step = STEP_OUT;
                w.next_step = STEP_IDLE;
            end
            default:
            begin
                w.next_step = STEP_CLEAR;
            end
        endcase
        return w;
    endfunction

    // Smallest k with 2**k >= n; 0 for n of 0 or 1.
    function automatic logic [3:0] ceil_log2_cnt(input logic [CNT_W-1:0] n);
        logic [3:0] res;
        logic       found;
        res   = '0;
        found = 1'b0;
        for (int i = 0; i <= CNT_W; i++)
        begin
            if (!found && ((CNT_W+1)'(1) << i) >= {1'b0, n})
            begin
                res   = 4'(i);
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/max_tournament_tree_unit.sv =====
// Max tournament tree with point update, driven by a microcoded sequencer.
// Depends on mtt_pkg for node types, sequencer codes and the microcode ROM.

// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the number of
// valid leaves; any write also clears the whole tree. Values above MAX_LEAVES
// are saturated. cfg_ready is always high.
// Each input transaction on the slave side carries a leaf index and a 64-bit
// value. An index below the leaf count overwrites that leaf and the parents
// on its path are recomputed, ties going to the left child; other indices are
// rejected and leave the tree unchanged. Every input gives exactly one result
// transaction on the master side: the rejected flag, the root maximum and the
// lowest leaf index holding it (both zero when the leaf count is zero).
// Timing: an accepted update climbs one tree level per cycle, and a rejected
// one skips the climb. The next input is taken only after the result has been
// loaded into the output register. The climb is bound by the single write
// port of the node memory.
// After reset, and after each configuration write, a clearing pass sweeps the
// node memory one entry per cycle (512 entries with the default MAX_LEAVES)
// while no input is taken. A stalled receiver holds the output register; the
// sequencer then waits at its output step and takes no further input.

module max_tournament_tree_unit
    import mtt_pkg::*;
#(
    parameter int MAX_LEAVES = DEFAULT_MAX_LEAVES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CNT_W-1:0]              cfg_data,   // number of valid leaves
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [LEAF_IDX_W+VALUE_W-1:0] s_tdata,    // leaf_index, leaf_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [LEAF_IDX_W+VALUE_W-1:0] m_tdata,    // winner_index, best_value
    output logic                          m_tuser     // rejected
);

    // The leaf count can never exceed what its register holds.
    localparam int CNT_MAX  = (1 << CNT_W) - 1;
    localparam int CNT_CAP  = (MAX_LEAVES < CNT_MAX) ? MAX_LEAVES : CNT_MAX;
    localparam int NODE_AW  = $clog2(CNT_CAP) + 1;
    localparam int DEPTH    = 1 << NODE_AW;
    localparam int LOG_W    = $clog2(NODE_AW);

    // Node memory, not reset: the clearing pass zeroes it.
    node_t mem [DEPTH];

    step_t                   step_reg;
    logic [NODE_AW-1:0]      clr_addr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [LOG_W-1:0]        base_log_reg;
    logic [LEAF_IDX_W-1:0]   idx_reg;
    logic [VALUE_W-1:0]      val_reg;
    logic [NODE_AW-1:0]      pos_reg;
    node_t                   cur_reg;
    node_t                   rd_data_reg;
    logic                    rej_reg;
    logic                    m_tvalid_reg;
    logic [LEAF_IDX_W+VALUE_W-1:0] m_tdata_reg;
    logic                    m_tuser_reg;

    uword_t                  uw;
    logic                    cfg_acc;
    logic                    in_acc;
    logic                    out_full;
    logic                    out_ld;
    logic                    rej;
    logic [NODE_AW-1:0]      leaf_pos;
    logic [NODE_AW-1:0]      parent;
    logic                    take_cur;
    node_t                   parent_node;
    logic                    jump;
    logic [CNT_W-1:0]        cnt_sat;

    logic                    mem_we;
    logic [NODE_AW-1:0]      mem_wa;
    node_t                   mem_wd;
    logic                    mem_re;
    logic [NODE_AW-1:0]      mem_ra;

    assign uw        = ucode_rom(step_reg);
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign s_tready  = uw.in_rdy;
    assign in_acc    = s_tvalid & s_tready;
    assign out_full  = m_tvalid_reg & ~m_tready;
    assign out_ld    = uw.out_load & ~out_full;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign cnt_sat   = (int'(cfg_data) > CNT_CAP) ? CNT_W'(CNT_CAP) : cfg_data;

    // A leaf index at or beyond the count is rejected.
    assign rej       = {1'b0, idx_reg} >= count_reg;
    assign leaf_pos  = (NODE_AW'(1) << base_log_reg) + NODE_AW'(idx_reg);
    assign parent    = pos_reg >> 1;

    // The climbing node is a left child when its address is even; ties go left.
    always_comb
    begin
        if (!pos_reg[0])
        begin
            take_cur = cur_reg.value >= rd_data_reg.value;
        end
        else
        begin
            take_cur = cur_reg.value > rd_data_reg.value;
        end
        parent_node = take_cur ? cur_reg : rd_data_reg;
    end

    always_comb
    begin
        unique case (uw.cond)
            CND_NEVER:      jump = 1'b0;
            CND_CLR_BUSY:   jump = ~(&clr_addr_reg);
            CND_NO_INPUT:   jump = ~in_acc;
            CND_LEAF_SKIP:  jump = rej | (leaf_pos == NODE_AW'(1));
            CND_CLIMB_MORE: jump = parent != NODE_AW'(1);
            CND_OUT_FULL:   jump = out_full;
            default:        jump = 1'b0;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_addr_reg;
        mem_wd = '0;
        unique case (uw.wr)
            WR_NONE:
            begin
                mem_we = 1'b0;
            end
            WR_CLEAR:
            begin
                mem_we = 1'b1;
            end
            WR_LEAF:
            begin
                mem_we = ~rej;
                mem_wa = leaf_pos;
                mem_wd = '{value: val_reg, winner: idx_reg};
            end
            WR_CLIMB:
            begin
                mem_we = 1'b1;
                mem_wa = parent;
                mem_wd = parent_node;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mem_re = 1'b1;
        mem_ra = NODE_AW'(1);
        unique case (uw.rd)
            RD_NONE:      mem_re = 1'b0;
            RD_LEAF_SIB:  mem_ra = leaf_pos ^ NODE_AW'(1);
            RD_CLIMB_SIB: mem_ra = parent ^ NODE_AW'(1);
            RD_ROOT:      mem_ra = NODE_AW'(1);
            default:      mem_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            base_log_reg <= '0;
            idx_reg      <= '0;
            val_reg      <= '0;
            pos_reg      <= '0;
            cur_reg      <= '0;
            rej_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                // A new leaf count restarts the clearing pass.
                count_reg    <= cnt_sat;
                base_log_reg <= LOG_W'(ceil_log2_cnt(cnt_sat));
                step_reg     <= STEP_CLEAR;
                clr_addr_reg <= '0;
            end
            else
            begin
                step_reg <= jump ? uw.jump_step : uw.next_step;
                if (uw.wr == WR_CLEAR)
                begin
                    clr_addr_reg <= clr_addr_reg + NODE_AW'(1);
                end
                if (in_acc)
                begin
                    idx_reg <= s_tdata[LEAF_IDX_W-1:0];
                    val_reg <= s_tdata[LEAF_IDX_W+VALUE_W-1:LEAF_IDX_W];
                end
                if (uw.wr == WR_LEAF)
                begin
                    rej_reg <= rej;
                    pos_reg <= leaf_pos;
                    cur_reg <= '{value: val_reg, winner: idx_reg};
                end
                if (uw.wr == WR_CLIMB)
                begin
                    pos_reg <= parent;
                    cur_reg <= parent_node;
                end
            end

            if (out_ld)
            begin
                m_tvalid_reg <= 1'b1;
                m_tuser_reg  <= rej_reg;
                if (count_reg == '0)
                begin
                    m_tdata_reg <= '0;
                end
                else
                begin
                    m_tdata_reg <= {rd_data_reg.value, rd_data_reg.winner};
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== verif/tb_max_tournament_tree_unit.sv =====
// Self-checking testbench for max_tournament_tree_unit: leaf writes are streamed in and each
// root report is compared with a behavioural max tree kept inside the bench.
// Depends on mtt_pkg and on the max_tournament_tree_unit RTL.

module tb_max_tournament_tree_unit;
    import mtt_pkg::*;

    localparam int NODE_COUNT  = 2 * DEFAULT_MAX_LEAVES;
    localparam int CYCLE_LIMIT = 600000;

    // Packed so that the bit layout matches the tdata/tuser packing of the ports.
    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [LEAF_IDX_W-1:0] index;
    } leaf_write_t;

    typedef struct packed {
        logic                  rejected;
        logic [VALUE_W-1:0]    best;
        logic [LEAF_IDX_W-1:0] winner;
    } root_report_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CNT_W-1:0]              cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [LEAF_IDX_W+VALUE_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [LEAF_IDX_W+VALUE_W-1:0] m_tdata;
    logic                          m_tuser;

    leaf_write_t  write_q[$];
    root_report_t root_q[$];

    // Behavioural copy of the tree: node 1 is the root, node p has children 2p and 2p+1.
    logic [VALUE_W-1:0]    node_value  [NODE_COUNT];
    logic [LEAF_IDX_W-1:0] node_winner [NODE_COUNT];
    int unsigned           live_leaves;
    int unsigned           leaf_base;

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned cycle_count;
    bit          in_taken;

    max_tournament_tree_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // A leaf count write saturates at the leaf capacity and empties the tree.
    function automatic void load_leaf_count(input logic [CNT_W-1:0] n);
        int unsigned c;
        c = (n > DEFAULT_MAX_LEAVES) ? DEFAULT_MAX_LEAVES : n;
        live_leaves = c;
        leaf_base   = 1;
        while (leaf_base < c)
        begin
            leaf_base = leaf_base << 1;
        end
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            node_value[i]  = '0;
            node_winner[i] = '0;
        end
    endfunction

    // Writes one leaf, replays the path up to the root (ties to the left child) and
    // returns the report the block should give for this transaction.
    function automatic root_report_t apply_leaf_write(input leaf_write_t w);
        root_report_t r;
        int unsigned  pos;
        int unsigned  lc;
        r.rejected = (w.index >= live_leaves);
        if (!r.rejected)
        begin
            pos              = leaf_base + w.index;
            node_value[pos]  = w.value;
            node_winner[pos] = w.index;
            while (pos > 1)
            begin
                pos = pos >> 1;
                lc  = pos << 1;
                if (node_value[lc] >= node_value[lc + 1])
                begin
                    node_value[pos]  = node_value[lc];
                    node_winner[pos] = node_winner[lc];
                end
                else
                begin
                    node_value[pos]  = node_value[lc + 1];
                    node_winner[pos] = node_winner[lc + 1];
                end
            end
        end
        if (live_leaves == 0)
        begin
            r.winner = '0;
            r.best   = '0;
        end
        else
        begin
            r.winner = node_winner[1];
            r.best   = node_value[1];
        end
        return r;
    endfunction

    // Values lean towards extremes and a narrow band so that ties happen often.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'($urandom_range(0, 7));
            3:       return ~VALUE_W'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly indices inside the valid range, the rest anywhere so that some are rejected.
    function automatic logic [LEAF_IDX_W-1:0] pick_index(input int unsigned leaves);
        if (leaves != 0 && $urandom_range(0, 99) < 85)
            return LEAF_IDX_W'($urandom_range(0, leaves - 1));
        return LEAF_IDX_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_write(input logic [LEAF_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        write_q.push_back('{value: val, index: idx});
        outstanding++;
    endtask

    task automatic write_leaf_count(input logic [CNT_W-1:0] n);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        load_leaf_count(n);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Returns once every queued write has been answered and checked.
    task automatic wait_quiet();
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Driver: presents the next pending write once the current transaction has gone.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (write_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= write_q.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Monitor: predicts on every accepted write and checks every accepted report.
    always @(posedge clk)
    begin
        root_report_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                root_q.push_back(apply_leaf_write(leaf_write_t'(s_tdata)));
            end
            if (m_tvalid && m_tready)
            begin
                if (root_q.size() == 0)
                begin
                    $error("unexpected result transaction: tuser %b tdata %h", m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = root_q.pop_front();
                    outstanding--;
                    if (m_tuser !== want.rejected)
                    begin
                        $error("rejected: expected %b, got %b", want.rejected, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[LEAF_IDX_W-1:0] !== want.winner)
                    begin
                        $error("winner_index: expected %0d, got %0d", want.winner,
                               m_tdata[LEAF_IDX_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[LEAF_IDX_W +: VALUE_W] !== want.best)
                    begin
                        $error("best_value: expected %h, got %h", want.best,
                               m_tdata[LEAF_IDX_W +: VALUE_W]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("max_tournament_tree_unit test failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_leaves [10];
        int unsigned phase_items  [10];
        int unsigned leaves;
        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        outstanding        = 0;
        fail_count         = 0;
        cycle_count        = 0;
        in_taken           = 1'b0;
        load_leaf_count('0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty tree straight after reset: everything is rejected and the report is zero.
        queue_write(8'd0, '1);
        queue_write(8'd255, {32{2'b01}});
        wait_quiet();

        // An oversized count saturates to the full capacity; ties must go to the lower index.
        write_leaf_count(9'd511);
        queue_write(8'd0, '0);
        queue_write(8'd255, '1);
        queue_write(8'd128, '1);
        queue_write(8'd0, '1);
        queue_write(8'd0, ~64'd1);
        queue_write(8'd128, '0);
        queue_write(8'd170, {32{2'b10}});
        queue_write(8'd85, {32{2'b01}});
        queue_write(8'd255, '0);
        wait_quiet();

        // Count that is not a power of two: padding leaves must never win.
        write_leaf_count(9'd5);
        queue_write(8'd4, 64'd7);
        queue_write(8'd5, 64'd9);
        queue_write(8'd255, 64'd9);
        queue_write(8'd3, 64'd7);
        queue_write(8'd0, 64'd7);
        wait_quiet();

        // Single leaf: the leaf is the root.
        write_leaf_count(9'd1);
        queue_write(8'd0, 64'd3);
        queue_write(8'd1, 64'd4);
        wait_quiet();

        write_leaf_count(9'd2);
        queue_write(8'd1, 64'd10);
        queue_write(8'd0, 64'd10);
        wait_quiet();

        // Random phases, each with its own leaf count and handshake pressure.
        phase_leaves = '{256, 3, 77, 300, 2, 1, 200, 0, 129, 511};
        phase_items  = '{60, 60, 60, 60, 60, 60, 60, 15, 60, 60};
        for (int p = 0; p < 10; p++)
        begin
            write_leaf_count(CNT_W'(phase_leaves[p]));
            leaves = live_leaves;
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 87;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 87;
                end
                default:
                begin
                    sender_idle_pct    = 24;
                    receiver_stall_pct = 24;
                end
            endcase
            for (int i = 0; i < phase_items[p]; i++)
            begin
                queue_write(pick_index(leaves), pick_value());
            end
            wait_quiet();
        end

        // Let any stray result show up before the verdict.
        repeat (16) @(posedge clk);
        if (root_q.size() != 0)
        begin
            $error("%0d expected results never arrived", root_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("max_tournament_tree_unit test passed");
        else
            $display("max_tournament_tree_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mtt_pkg.sv
hdl/max_tournament_tree_unit.sv
verif/tb_max_tournament_tree_unit.sv
